// ----- rtl/pdsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsr_pkg: shared types and constants of the duty slew ramp unit
// Holds the field widths, register indexes, the command and status words
// between controller and datapath, and their codes.
// ----------------------------------------------------------------------------
package pdsr_pkg;

	localparam int DUTY_W    = 16;
	localparam int SPAN_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_CNT_W = 6;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICK       = 2'd3;

	// How a word updates the duty.
	localparam logic [1:0] KIND_KEEP = 2'd0;
	localparam logic [1:0] KIND_JUMP = 2'd1;
	localparam logic [1:0] KIND_STEP = 2'd2;
	localparam logic [1:0] KIND_SLOW = 2'd3;

	// Divider operand selection.
	localparam logic [1:0] SRC_STEP = 2'd0;
	localparam logic [1:0] SRC_UNIT = 2'd1;
	localparam logic [1:0] SRC_NEED = 2'd2;

	typedef struct packed {
		logic       load;
		logic       classify;
		logic       div_start;
		logic [1:0] div_src;
		logic       apply;
		logic [1:0] kind;
	} pdsr_cmd_t;

	typedef struct packed {
		logic equal;
		logic jump;
		logic step_case;
		logic div_busy;
	} pdsr_stat_t;

endpackage

// ----- rtl/pdsr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsr_div: restoring divider, one quotient bit per cycle
// Divides a 32-bit dividend by a 16-bit divisor, or only the upper
// 16 dividend bits. A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module pdsr_div
	import pdsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              wide,
	input  logic [SPAN_W-1:0] dividend,
	input  logic [DUTY_W-1:0] divisor,
	output logic              busy,
	output logic [SPAN_W-1:0] quotient
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SPAN_W-1:0]    num_q;
	logic [DUTY_W-1:0]    den_q;
	logic [DUTY_W-1:0]    rem_q;
	logic [DUTY_W:0]      trial;
	logic                 fits;

	assign trial = {rem_q, num_q[SPAN_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign busy  = (cnt_q != '0);
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= wide ? DIV_CNT_W'(SPAN_W) : DIV_CNT_W'(DUTY_W);
		end else if (busy) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[SPAN_W-2:0], fits};
			rem_q <= fits ? DUTY_W'(trial - {1'b0, den_q}) : trial[DUTY_W-1:0];
		end
	end

endmodule

// ----- rtl/pdsr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsr_dp: datapath of the duty slew ramp unit
// Holds the configuration registers, the duty and tick counter state, the
// word being worked on, the shared divider and the update logic.
// ----------------------------------------------------------------------------
module pdsr_dp
	import pdsr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DUTY_W-1:0]    cfg_data,
	input  logic [DUTY_W-1:0]    duty_req,
	input  pdsr_cmd_t            cmd,
	output pdsr_stat_t           stat,
	output logic [DUTY_W-1:0]    duty,
	output logic                 moving
);

	logic [DUTY_W-1:0] full_scale_q;
	logic [DUTY_W-1:0] ramp_up_q;
	logic [DUTY_W-1:0] ramp_down_q;
	logic [DUTY_W-1:0] tick_q;
	logic [DUTY_W-1:0] duty_q;
	logic [DUTY_W-1:0] cnt_q;
	logic              moving_q;
	logic [DUTY_W-1:0] tgt_q;
	logic [SPAN_W-1:0] span_q;
	logic              up_dir_q;

	logic              up_dir;
	logic [DUTY_W-1:0] rt;
	logic              div_busy;
	logic              div_wide;
	logic [SPAN_W-1:0] div_num;
	logic [DUTY_W-1:0] div_den;
	logic [SPAN_W-1:0] quo;
	logic [DUTY_W-1:0] step;
	logic [DUTY_W:0]   sum;
	logic [DUTY_W-1:0] diff;
	logic [DUTY_W-1:0] cnt_inc;
	logic [DUTY_W-1:0] duty_d;
	logic [DUTY_W-1:0] cnt_d;

	// Classification of the word against the current duty.
	assign up_dir = tgt_q > duty_q;
	assign rt     = up_dir ? ramp_up_q : ramp_down_q;

	assign stat.equal     = (tgt_q == duty_q);
	assign stat.jump      = (rt == '0) || (rt <= tick_q);
	assign stat.step_case = {{(SPAN_W-DUTY_W){1'b0}}, rt} <= span_q;
	assign stat.div_busy  = div_busy;

	always_comb begin
		div_wide = 1'b0;
		div_num  = '0;
		div_den  = '0;
		case (cmd.div_src)
			SRC_STEP: begin
				div_wide = 1'b1;
				div_num  = span_q;
				div_den  = rt;
			end
			SRC_UNIT: begin
				div_num = {rt, {DUTY_W{1'b0}}};
				div_den = full_scale_q;
			end
			SRC_NEED: begin
				div_num = {quo[DUTY_W-1:0], {DUTY_W{1'b0}}};
				div_den = tick_q;
			end
			default: begin
				div_num = '0;
			end
		endcase
	end

	pdsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.wide     (div_wide),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (quo)
	);

	// Duty and counter update for the selected case.
	assign step    = quo[DUTY_W-1:0];
	assign sum     = {1'b0, duty_q} + {1'b0, step};
	assign diff    = duty_q - step;
	assign cnt_inc = cnt_q + DUTY_W'(1);

	always_comb begin
		duty_d = duty_q;
		cnt_d  = cnt_q;
		case (cmd.kind)
			KIND_KEEP: begin
				duty_d = duty_q;
			end
			KIND_JUMP: begin
				duty_d = tgt_q;
			end
			KIND_STEP: begin
				if ({1'b0, tgt_q} >= sum) begin
					duty_d = sum[DUTY_W-1:0];
				end else if ((duty_q >= step) && (tgt_q <= diff)) begin
					duty_d = diff;
				end else begin
					duty_d = tgt_q;
				end
			end
			KIND_SLOW: begin
				if (cnt_inc >= step) begin
					duty_d = up_dir_q ? duty_q + DUTY_W'(1) : duty_q - DUTY_W'(1);
					cnt_d  = '0;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			default: begin
				duty_d = duty_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= DUTY_W'(1000);
			ramp_up_q    <= '0;
			ramp_down_q  <= '0;
			tick_q       <= DUTY_W'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FULL_SCALE: full_scale_q <= cfg_data;
				REG_RAMP_UP:    ramp_up_q    <= cfg_data;
				REG_RAMP_DOWN:  ramp_down_q  <= cfg_data;
				REG_TICK:       tick_q       <= cfg_data;
				default:        tick_q       <= tick_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q   <= '0;
			cnt_q    <= '0;
			moving_q <= 1'b0;
		end else if (cmd.apply) begin
			duty_q   <= duty_d;
			cnt_q    <= cnt_d;
			moving_q <= (cmd.kind != KIND_KEEP);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q  <= (duty_req > full_scale_q) ? full_scale_q : duty_req;
			span_q <= tick_q * full_scale_q;
		end
		if (cmd.classify) begin
			up_dir_q <= up_dir;
		end
	end

	assign duty   = duty_q;
	assign moving = moving_q;

endmodule

// ----- rtl/pdsr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsr_ctrl: controller of the duty slew ramp unit
// Sequences load, classification, divisions and update of one word, and
// owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module pdsr_ctrl
	import pdsr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  pdsr_stat_t stat,
	output pdsr_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLASS = 3'd1;
	localparam logic [2:0] S_DIV1  = 3'd2;
	localparam logic [2:0] S_DIV2  = 3'd3;
	localparam logic [2:0] S_APPLY = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] kind_q;
	logic [1:0] kind_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd      = '0;
		cmd.kind = kind_q;
		state_d  = state_q;
		kind_d   = kind_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CLASS;
				end
			end
			S_CLASS: begin
				cmd.classify = 1'b1;
				if (stat.equal) begin
					kind_d  = KIND_KEEP;
					state_d = S_APPLY;
				end else if (stat.jump) begin
					kind_d  = KIND_JUMP;
					state_d = S_APPLY;
				end else if (stat.step_case) begin
					cmd.div_start = 1'b1;
					cmd.div_src   = SRC_STEP;
					kind_d        = KIND_STEP;
					state_d       = S_DIV1;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_src   = SRC_UNIT;
					kind_d        = KIND_SLOW;
					state_d       = S_DIV1;
				end
			end
			S_DIV1: begin
				if (!stat.div_busy) begin
					if (kind_q == KIND_SLOW) begin
						cmd.div_start = 1'b1;
						cmd.div_src   = SRC_NEED;
						state_d       = S_DIV2;
					end else begin
						state_d = S_APPLY;
					end
				end
			end
			S_DIV2: begin
				if (!stat.div_busy) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				if (out_free) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= KIND_KEEP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.apply) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/pwm_duty_slew_ramp_unit.sv -----
`timescale 1ns / 1ps
// Path: a word where the duty holds or jumps needs no division, a
// multi-unit step uses one 32-bit division, and the slow case uses two
// 16-bit divisions back to back on the one divider.
// Flow: one word at a time; the next word can be taken in the same cycle
// that a result is presented.
// Reset: duty, tick counter and handshakes clear; registers take defaults.
// ----------------------------------------------------------------------------
// pwm_duty_slew_ramp_unit: slew-rate limited PWM duty ramp
// Each input word carries a target duty. The target is clamped to full
// scale and the output duty moves toward it at a rate set by the ramp time.
// ----------------------------------------------------------------------------
module pwm_duty_slew_ramp_unit
	import pdsr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port: index 0 full scale, 1 ramp up time,
	// 2 ramp down time, 3 tick period.
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DUTY_W-1:0]    cfg_data,
	// Input channel.
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [DUTY_W-1:0]    duty_req,
	// Output channel.
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DUTY_W-1:0]    duty,
	output logic                 moving
);

	// The controller walks each word through load, classification, up to
	// two divisions and the final update. The datapath holds all state and
	// arithmetic; the two talk only through the command and status words.
	pdsr_cmd_t  cmd;
	pdsr_stat_t stat;

	pdsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The duty state register doubles as the output register. It is only
	// updated once the previous result has been taken, so a waiting result
	// never changes under the consumer, while the next word may already be
	// accepted and worked on.
	pdsr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.duty_req    (duty_req),
		.cmd         (cmd),
		.stat        (stat),
		.duty        (duty),
		.moving      (moving)
	);

	// Only one word is in flight: the input closes right after an accept.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a word is in flight");

	// The divider is idle whenever the block is ready for a new word.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.div_busy)
		else $error("divider busy while idle");

	// The duty only changes together with a new result being presented.
	a_duty_result: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(duty) |-> out_valid)
		else $error("duty changed without a result");

	// An update never overwrites a result still waiting to be taken.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> !out_valid || out_ready)
		else $error("result overwritten before it was taken");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the PWM duty slew ramp unit
// A directed table walks the hold, jump, step and slow paths plus the corner
// settings, then random phases with fresh register settings drive runs of
// repeated targets. Every word is predicted here and compared on the way out.
// ----------------------------------------------------------------------------
module tb;
	import pdsr_pkg::*;

	// Random word budget, and the settle time before a register write or the
	// end of the run.
	localparam int WORDS_TOTAL   = 1050;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              moving;
	} duty_result_t;

	// One row of the directed table: either a register write or a word.
	// For a word, value is the target; typed marks a row whose result is
	// written out in the table rather than taken from the predictor.
	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [DUTY_W-1:0]    value;
		logic                 typed;
		logic [DUTY_W-1:0]    exp_duty;
		logic                 exp_moving;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DUTY_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [DUTY_W-1:0]    duty_req;
	logic                 out_valid;
	logic                 out_ready;
	logic [DUTY_W-1:0]    duty;
	logic                 moving;

	// Shadow copy of the registers and of the ramp state.
	logic [DUTY_W-1:0] full_scale;
	logic [DUTY_W-1:0] ramp_up;
	logic [DUTY_W-1:0] ramp_down;
	logic [DUTY_W-1:0] tick;
	logic [DUTY_W-1:0] duty_model;
	logic [DUTY_W-1:0] tick_count;

	duty_result_t duty_expected [$];
	plan_row_t    plan [$];

	int  words_sent;
	int  words_checked;
	int  mismatches;
	int  phases;
	int  n_hold, n_jump, n_step, n_slow;
	// When set, neither side idles: back-to-back stretches.
	bit  calm;

	pwm_duty_slew_ramp_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.duty_req   (duty_req),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.duty       (duty),
		.moving     (moving)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predict one tick: clamp the target, choose the ramp time for the
	// direction, then hold, jump, step by several units, or creep one unit
	// each time the tick counter reaches its threshold.
	function automatic duty_result_t advance_duty(input logic [DUTY_W-1:0] target);
		logic [SPAN_W-1:0] tgt, cur, rt, span, step;
		logic [DUTY_W-1:0] per_unit, needed;
		duty_result_t      res;
		tgt = (target > full_scale) ? SPAN_W'(full_scale) : SPAN_W'(target);
		cur = SPAN_W'(duty_model);
		rt = (tgt > cur) ? SPAN_W'(ramp_up) : SPAN_W'(ramp_down);
		span = SPAN_W'(tick) * SPAN_W'(full_scale);
		res.moving = 1'b1;
		if (tgt == cur) begin
			res.moving = 1'b0;
			n_hold++;
		end else if (rt == 0 || rt <= SPAN_W'(tick)) begin
			cur = tgt;
			n_jump++;
		end else if (rt <= span) begin
			step = (span / rt) & 32'hFFFF;
			if (tgt >= cur + step)
				cur = cur + step;
			else if (cur >= step && tgt <= cur - step)
				cur = cur - step;
			else
				cur = tgt;
			n_step++;
		end else begin
			// A zero divisor reads back as all ones, like an unguarded divider.
			per_unit = (full_scale == 0) ? 16'hFFFF : DUTY_W'(rt / SPAN_W'(full_scale));
			needed = (tick == 0) ? 16'hFFFF : per_unit / tick;
			tick_count = tick_count + 16'd1;
			if (tick_count >= needed) begin
				cur = (tgt > cur) ? cur + 1 : cur - 1;
				tick_count = '0;
			end
			n_slow++;
		end
		duty_model = cur[DUTY_W-1:0];
		res.duty = duty_model;
		return res;
	endfunction

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [DUTY_W-1:0] val);
		plan_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.value = val;
		return r;
	endfunction

	function automatic plan_row_t word_row(input logic [DUTY_W-1:0] tgt);
		plan_row_t r;
		r = '0;
		r.value = tgt;
		return r;
	endfunction

	function automatic plan_row_t checked_row(input logic [DUTY_W-1:0] tgt,
			input logic [DUTY_W-1:0] d, input logic m);
		plan_row_t r;
		r = word_row(tgt);
		r.typed = 1'b1;
		r.exp_duty = d;
		r.exp_moving = m;
		return r;
	endfunction

	// Offer one word after a random gap. Valid stays high from the previous
	// word when the gap is zero, so it is never dropped and raised in one step.
	task automatic offer_word(input logic [DUTY_W-1:0] tgt, input logic typed,
			input duty_result_t typed_res);
		int           gap;
		duty_result_t res;
		gap = calm ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		duty_req <= tgt;
		do @(posedge clk); while (!in_ready);
		res = advance_duty(tgt);
		duty_expected.push_back(typed ? typed_res : res);
		words_sent++;
	endtask

	// Drop valid, let every outstanding word come back, then give the block
	// time to fall idle.
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (duty_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes land on consecutive cycles; release_cfg lowers the enable after
	// the last one.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_FULL_SCALE: full_scale = val;
			REG_RAMP_UP:    ramp_up = val;
			REG_RAMP_DOWN:  ramp_down = val;
			REG_TICK:       tick = val;
			default: ;
		endcase
	endtask

	task automatic release_cfg();
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Ramp time drawn so that each phase lands on jump, step or slow pacing;
	// the slow draw keeps the threshold small enough for the duty to move.
	function automatic logic [DUTY_W-1:0] pick_ramp(input logic [DUTY_W-1:0] fs,
			input logic [DUTY_W-1:0] tk);
		logic [SPAN_W-1:0] span, top, slow_top;
		span = SPAN_W'(tk) * SPAN_W'(fs);
		top = (span > 32'hFFFF) ? 32'hFFFF : span;
		slow_top = (span * 8 + 8 > 32'hFFFF) ? 32'hFFFF : span * 8 + 8;
		case ($urandom_range(0, 5))
			0: return '0;
			1: return DUTY_W'($urandom_range(1, tk));
			2: begin
				if (top > SPAN_W'(tk))
					return DUTY_W'($urandom_range(tk + 1, top));
				return 16'hFFFF;
			end
			3: begin
				if (span < 32'hFFFF)
					return DUTY_W'($urandom_range(span + 1, slow_top));
				return 16'hFFFF;
			end
			4: return DUTY_W'($urandom);
			default: return 16'hFFFF;
		endcase
	endfunction

	task automatic random_setting();
		logic [DUTY_W-1:0] fs, tk;
		case ($urandom_range(0, 5))
			0: fs = 16'd1;
			1: fs = 16'hFFFF;
			5: fs = DUTY_W'($urandom_range(1, 65535));
			default: fs = DUTY_W'($urandom_range(2, 2000));
		endcase
		case ($urandom_range(0, 5))
			4: tk = 16'hFFFF;
			5: tk = DUTY_W'($urandom_range(1, 65535));
			default: tk = DUTY_W'($urandom_range(1, 4));
		endcase
		quiesce();
		write_reg(REG_FULL_SCALE, fs);
		write_reg(REG_TICK, tk);
		write_reg(REG_RAMP_UP, pick_ramp(fs, tk));
		write_reg(REG_RAMP_DOWN, pick_ramp(fs, tk));
		release_cfg();
		calm = ($urandom_range(0, 3) == 0);
	endtask

	// Targets mostly fall inside full scale; the rest are the ends of the
	// field and raw 16-bit noise that exercises the clamp.
	function automatic logic [DUTY_W-1:0] pick_target();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return full_scale;
			2: return 16'hFFFF;
			3: return DUTY_W'($urandom);
			default: return DUTY_W'($urandom_range(0, full_scale));
		endcase
	endfunction

	// Result checker: every word taken from the block is matched against the
	// oldest prediction.
	always @(posedge clk) begin : check_words
		duty_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (duty_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected word duty=%0d moving=%0b",
						$realtime, duty, moving);
			end else begin
				want = duty_expected.pop_front();
				words_checked++;
				if (duty !== want.duty || moving !== want.moving) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: word %0d duty exp %0d got %0d, moving exp %0b got %0b",
							$realtime, words_checked, want.duty, duty,
							want.moving, moving);
				end
			end
		end
	end

	// Output side: each word waits out a random stall.
	initial begin : receiver
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 8);
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Main sequence: reset, directed table, random phases, drain, verdict.
	initial begin : stimulus
		logic [DUTY_W-1:0] tgt;
		duty_result_t      typed_res;
		int                run, phase_len, k;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		duty_req = '0;
		out_ready = 1'b0;
		calm = 1'b0;
		full_scale = 16'd1000;
		ramp_up = '0;
		ramp_down = '0;
		tick = 16'd1;
		duty_model = '0;
		tick_count = '0;

		// Reset defaults: every move is a jump, and targets clamp to 1000.
		plan.push_back(checked_row(16'd0, 16'd0, 1'b0));
		plan.push_back(checked_row(16'hFFFF, 16'd1000, 1'b1));
		plan.push_back(checked_row(16'd1000, 16'd1000, 1'b0));
		plan.push_back(checked_row(16'd0, 16'd0, 1'b1));
		plan.push_back(checked_row(16'd500, 16'd500, 1'b1));
		// Ten units per tick both ways, including the snap when within a step.
		plan.push_back(cfg_row(REG_RAMP_UP, 16'd100));
		plan.push_back(cfg_row(REG_RAMP_DOWN, 16'd100));
		plan.push_back(word_row(16'd1000));
		plan.push_back(word_row(16'd505));
		plan.push_back(word_row(16'd0));
		// Slow pacing: a long rise threshold, a short fall threshold.
		plan.push_back(cfg_row(REG_RAMP_UP, 16'hFFFF));
		plan.push_back(cfg_row(REG_RAMP_DOWN, 16'd3000));
		plan.push_back(word_row(16'd1000));
		plan.push_back(word_row(16'd1000));
		plan.push_back(word_row(16'd0));
		plan.push_back(word_row(16'd0));
		// Register extremes: ramp times no longer than the tick jump outright.
		plan.push_back(cfg_row(REG_FULL_SCALE, 16'hFFFF));
		plan.push_back(cfg_row(REG_RAMP_UP, 16'd1));
		plan.push_back(cfg_row(REG_RAMP_DOWN, 16'hFFFF));
		plan.push_back(cfg_row(REG_TICK, 16'hFFFF));
		plan.push_back(checked_row(16'hFFFF, 16'hFFFF, 1'b1));
		plan.push_back(checked_row(16'd0, 16'd0, 1'b1));
		plan.push_back(checked_row(16'd40000, 16'd40000, 1'b1));
		// Full scale lowered under the present duty: it ramps down from above.
		plan.push_back(cfg_row(REG_FULL_SCALE, 16'd100));
		plan.push_back(cfg_row(REG_RAMP_DOWN, 16'd50));
		plan.push_back(cfg_row(REG_TICK, 16'd1));
		plan.push_back(word_row(16'd0));
		// Zero full scale clamps every target to zero and divides by zero.
		plan.push_back(cfg_row(REG_FULL_SCALE, 16'd0));
		plan.push_back(word_row(16'd7));
		// Zero tick period also divides by zero on the slow path.
		plan.push_back(cfg_row(REG_FULL_SCALE, 16'd1000));
		plan.push_back(cfg_row(REG_RAMP_UP, 16'd500));
		plan.push_back(cfg_row(REG_TICK, 16'd0));
		plan.push_back(word_row(16'hFFFF));
		// Back to jumps so the duty returns to zero.
		plan.push_back(cfg_row(REG_TICK, 16'd1));
		plan.push_back(cfg_row(REG_RAMP_UP, 16'd0));
		plan.push_back(cfg_row(REG_RAMP_DOWN, 16'd0));
		plan.push_back(checked_row(16'd0, 16'd0, 1'b1));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (i == 0 || !plan[i-1].is_cfg)
					quiesce();
				write_reg(plan[i].reg_idx, plan[i].value);
				if (i == plan.size() - 1 || !plan[i+1].is_cfg)
					release_cfg();
			end else begin
				typed_res.duty = plan[i].exp_duty;
				typed_res.moving = plan[i].exp_moving;
				offer_word(plan[i].value, plan[i].typed, typed_res);
			end
		end

		// Random phases: a fresh register setting, then runs of one target
		// repeated so the ramp gets time to travel and settle.
		typed_res = '0;
		while (words_sent < WORDS_TOTAL) begin
			random_setting();
			phase_len = $urandom_range(30, 70);
			k = 0;
			while (k < phase_len && words_sent < WORDS_TOTAL) begin
				tgt = pick_target();
				run = $urandom_range(1, 12);
				repeat (run) begin
					offer_word(tgt, 1'b0, typed_res);
					k++;
				end
			end
			phases++;
		end

		quiesce();
		$display("Checked %0d words over %0d random settings after the directed table.",
			words_checked, phases);
		$display("Ticks by path: hold %0d, jump %0d, step %0d, slow %0d; mismatches %0d.",
			n_hold, n_jump, n_step, n_slow, mismatches);
		if (mismatches == 0 && duty_expected.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin : watchdog
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/pdsr_pkg.sv
rtl/pdsr_div.sv
rtl/pdsr_dp.sv
rtl/pdsr_ctrl.sv
rtl/pwm_duty_slew_ramp_unit.sv
tb/tb.sv
